>>> hdl/rpig_pkg.sv
// ----------------------------------------------------------------------------
// rpig_pkg
// Shared constants, types and the elaboration-time curve function for the
// pixel invert / grayscale-with-gamma block.
// ----------------------------------------------------------------------------
package rpig_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned PIX_W  = 3 * CHAN_W;
	localparam int unsigned LUMA_W = 16;
	localparam int unsigned SUM_W  = 24;

	localparam logic [15:0] W_RED   = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE  = 16'd4732;

	// floor(x / 255) = (x * RECIP_255) >> RECIP_SHIFT for x < 2^24
	localparam logic [24:0]  RECIP_255   = 25'd16843010;
	localparam int unsigned  RECIP_SHIFT = 32;
	localparam int unsigned  QUOT_W      = SUM_W + 25 - RECIP_SHIFT;

	typedef enum logic {
		MODE_INVERT = 1'b0,
		MODE_GRAY   = 1'b1
	} mode_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [63:0] floor_cbrt(input logic [63:0] n);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 20; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t * t <= n)
				r = t;
		end
		return r;
	endfunction

	// restoring long division, used only for table contents
	function automatic logic [63:0] floor_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// sRGB encoding curve, scaled by 255, for a Q0.16 luma code
	function automatic logic [7:0] curve_entry(input logic [63:0] y);
		logic [63:0] v, a, b, c, d, p, t, lim, o;
		lim = 64'd561 << 20;
		if (y * 64'd10000000 <= 64'd31308 * 64'd65536)
			return 8'(floor_div(64'd16473 * y, 64'd327680));
		v = y << 4;
		a = floor_sqrt(v << 20);
		b = floor_sqrt(a << 20);
		c = floor_cbrt(v << 40);
		d = floor_sqrt(c << 20);
		p = (b * d) >> 20;
		t = 64'd10761 * p;
		if (t <= lim)
			return 8'd0;
		o = floor_div(t - lim, 64'd40 << 20);
		return (o > 64'd255) ? 8'd255 : o[7:0];
	endfunction

endpackage

>>> hdl/rpig_luma.sv
// ----------------------------------------------------------------------------
// rpig_luma
// Two-stage luma datapath: weighted sum of the channels, then division by
// 255 through a reciprocal multiply, saturation and ROM index extraction.
// ----------------------------------------------------------------------------
module rpig_luma #(
	parameter int unsigned LUT_INDEX_BITS = 12
) (
	input  logic                     clk,
	input  logic                     en_s2,
	input  logic                     en_s3,
	input  rpig_pkg::pixel_t         pix_s1,
	output logic [LUT_INDEX_BITS-1:0] idx_s3
);
	import rpig_pkg::*;

	logic [SUM_W-1:0]          sum_s2;
	logic [SUM_W+24:0]         prod;
	logic [QUOT_W-1:0]         quot;
	logic [LUMA_W-1:0]         luma;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sum_s2 <= SUM_W'(W_RED * pix_s1.red) + SUM_W'(W_GREEN * pix_s1.green)
				+ SUM_W'(W_BLUE * pix_s1.blue);
		end
	end

	assign prod = (SUM_W+25)'(sum_s2) * (SUM_W+25)'(RECIP_255);
	assign quot = prod[RECIP_SHIFT +: QUOT_W];
	assign luma = quot[QUOT_W-1:LUMA_W] != '0 ? {LUMA_W{1'b1}} : quot[LUMA_W-1:0];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			idx_s3 <= luma[LUMA_W-1 -: LUT_INDEX_BITS];
		end
	end

endmodule

>>> hdl/rpig_curve_rom.sv
// ----------------------------------------------------------------------------
// rpig_curve_rom
// Gamma curve ROM, contents computed at elaboration, with registered read.
// ----------------------------------------------------------------------------
module rpig_curve_rom #(
	parameter int unsigned LUT_INDEX_BITS = 12
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [LUT_INDEX_BITS-1:0] idx,
	output logic [7:0]                data_s4
);
	import rpig_pkg::*;

	localparam int unsigned DEPTH = 2 ** LUT_INDEX_BITS;
	localparam int unsigned SHIFT = LUMA_W - LUT_INDEX_BITS;

	logic [7:0] rom_tbl [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		localparam logic [7:0] ENTRY = rpig_pkg::curve_entry(64'(i) << SHIFT);
		assign rom_tbl[i] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s4 <= rom_tbl[idx];
		end
	end

endmodule

>>> hdl/rgb_pixel_invert_or_gray_gamma.sv
// ----------------------------------------------------------------------------
// rgb_pixel_invert_or_gray_gamma
// Per-pixel invert, or Rec.709 luma followed by an sRGB gamma curve ROM.
//
//   channel   dir  tdata bits (low to high)        handshake
//   s_axis    in   blue[7:0] green[15:8] red[23:16]  tvalid/tready
//   m_axis    out  blue[7:0] green[15:8] red[23:16]  tvalid/tready
//   cfg       in   mode (bit 0)                    cfg_wr_en
//
// One pixel per clock sustained while m_axis_tready stays high; a pixel
// passes through these registered stages in order from input to output:
// input register, weighted sum, reciprocal divide by 255, and the registered
// curve ROM read. Each stage advances when the one ahead is empty or
// advancing, so bubbles collapse. Reset clears the valid bits and the mode
// register (invert).
// ----------------------------------------------------------------------------
module rgb_pixel_invert_or_gray_gamma #(
	parameter int unsigned LUT_INDEX_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [23:0]               s_axis_tdata,   // in_blue, in_green, in_red
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [23:0]               m_axis_tdata,   // out_blue, out_green, out_red
	input  logic                      cfg_wr_en,
	input  logic                      cfg_wr_data     // mode
);
	import rpig_pkg::*;

	mode_t  mode_q;
	logic   v_s1, v_s2, v_s3, v_s4;
	logic   en_s1, en_s2, en_s3, en_s4;
	mode_t  mode_s1, mode_s2, mode_s3, mode_s4;
	pixel_t pix_s1;
	pixel_t inv_s2, inv_s3, inv_s4;
	logic [LUT_INDEX_BITS-1:0] idx_s3;
	logic [7:0] gray_s4;

	assign en_s4 = !v_s4 || m_axis_tready;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INVERT;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			if (cfg_wr_en)
				mode_q <= mode_t'(cfg_wr_data);
			if (en_s1)
				v_s1 <= s_axis_tvalid;
			if (en_s2)
				v_s2 <= v_s1;
			if (en_s3)
				v_s3 <= v_s2;
			if (en_s4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pix_s1  <= pixel_t'({s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[7:0]});
			mode_s1 <= mode_q;
		end
		if (en_s2) begin
			inv_s2  <= ~pix_s1;
			mode_s2 <= mode_s1;
		end
		if (en_s3) begin
			inv_s3  <= inv_s2;
			mode_s3 <= mode_s2;
		end
		if (en_s4) begin
			inv_s4  <= inv_s3;
			mode_s4 <= mode_s3;
		end
	end

	rpig_luma #(
		.LUT_INDEX_BITS(LUT_INDEX_BITS)
	) u_luma (
		.clk    (clk),
		.en_s2  (en_s2),
		.en_s3  (en_s3),
		.pix_s1 (pix_s1),
		.idx_s3 (idx_s3)
	);

	rpig_curve_rom #(
		.LUT_INDEX_BITS(LUT_INDEX_BITS)
	) u_rom (
		.clk     (clk),
		.en      (en_s4),
		.idx     (idx_s3),
		.data_s4 (gray_s4)
	);

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = (mode_s4 == MODE_GRAY) ? {gray_s4, gray_s4, gray_s4}
		: {inv_s4.red, inv_s4.green, inv_s4.blue};

endmodule

>>> hdl/rpig_checker.sv
// ----------------------------------------------------------------------------
// rpig_checker
// Port-level checks for the pixel invert / grayscale block, bound to the top.
// ----------------------------------------------------------------------------
module rpig_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	logic s_xfer;
	assign s_xfer = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a stalled result");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_xfer, 4) && $past(m_axis_tready, 1) && $past(m_axis_tready, 2)
			&& $past(m_axis_tready, 3) |-> m_axis_tvalid)
		else $error("result missing four cycles after transfer");

endmodule

bind rgb_pixel_invert_or_gray_gamma rpig_checker u_rpig_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
